### rtl/qau_pkg.sv
`default_nettype none
package qau_pkg;

  localparam int FRAC_BITS_DEF   = 12;
  localparam int WORD_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int TOL_W = 12;
  localparam logic [TOL_W-1:0] TOL_RESET = 12'd4;

  // opcodes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_NEG   = 4'd2;
  localparam logic [3:0] OP_CONJ  = 4'd3;
  localparam logic [3:0] OP_SCALE = 4'd4;
  localparam logic [3:0] OP_DIV   = 4'd5;
  localparam logic [3:0] OP_MUL   = 4'd6;
  localparam logic [3:0] OP_DOT   = 4'd7;
  localparam logic [3:0] OP_LEN   = 4'd8;
  localparam logic [3:0] OP_NORM  = 4'd9;
  localparam logic [3:0] OP_UNIT  = 4'd10;
  localparam logic [3:0] OP_ROT   = 4'd11;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DZ      = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;
  localparam logic [1:0] ST_NOTUNIT = 2'd3;

  // decoded command as it travels from the front to the back
  typedef struct packed {
    logic [3:0] op;
    logic       valid_op;
    logic       zero_div;
  } qau_ctl_t;

  localparam int CTL_W = $bits(qau_ctl_t);

  // Hamilton product: term t of output o multiplies p[t] by q[o ^ t]
  function automatic logic ham_neg(input logic [1:0] o, input logic [1:0] t);
    logic n;
    case (o)
      2'd0:    n = (t != 2'd0);
      2'd1:    n = (t == 2'd3);
      2'd2:    n = (t == 2'd1);
      default: n = (t == 2'd2);
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

### rtl/quaternion_arithmetic_unit_top.sv
`default_nettype none
// Quaternion ALU, signed fixed point (WORD_BITS-bit words, FRAC_BITS fraction
// bits, Q3.12 by default). Push a command beat with quaternions a, b and a
// scalar; pop one result beat per command, in order. The front decodes each
// beat and drops it in a small command queue, so push keeps being taken while
// the back end works and while a finished result waits in the result queue,
// until the command queue is full. The back end runs one command at a time
// around a single (W+1)x(W+1) multiplier and a bit-serial divide / square-root
// unit. The multiplier and the serial unit set the back-end time per command;
// the queues only hide the spread between commands. unit_tolerance is written
// by unit_tolerance_we; the user must write it only while the block is idle,
// and the block itself does not enforce this.

module quaternion_arithmetic_unit_top #(
  parameter int WORD_BITS   = qau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS   = qau_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = qau_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        unit_tolerance_we,
  input  wire logic [qau_pkg::TOL_W-1:0]   unit_tolerance,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [3:0]                  cmd,
  input  wire logic signed [WORD_BITS-1:0] a_real,
  input  wire logic signed [WORD_BITS-1:0] a_i,
  input  wire logic signed [WORD_BITS-1:0] a_j,
  input  wire logic signed [WORD_BITS-1:0] a_k,
  input  wire logic signed [WORD_BITS-1:0] b_real,
  input  wire logic signed [WORD_BITS-1:0] b_i,
  input  wire logic signed [WORD_BITS-1:0] b_j,
  input  wire logic signed [WORD_BITS-1:0] b_k,
  input  wire logic signed [WORD_BITS-1:0] scalar,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed [WORD_BITS-1:0]      res_real,
  output logic signed [WORD_BITS-1:0]      res_i,
  output logic signed [WORD_BITS-1:0]      res_j,
  output logic signed [WORD_BITS-1:0]      res_k,
  output logic signed [WORD_BITS-1:0]      res_scalar,
  output logic                             is_unit,
  output logic [1:0]                       status
);

  localparam int W      = WORD_BITS;
  localparam int ITEM_W = qau_pkg::CTL_W + 9 * W;
  localparam int OUT_W  = 5 * W + 3;

  logic [qau_pkg::TOL_W-1:0] tol;
  logic [ITEM_W-1:0] item_in;
  logic [ITEM_W-1:0] item_q;
  logic              cq_empty;
  logic              cq_pop;
  logic [OUT_W-1:0]  res_d;
  logic [OUT_W-1:0]  res_q;
  logic              rq_full;
  logic              rq_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= qau_pkg::TOL_RESET;
    end else if (unit_tolerance_we) begin
      tol <= unit_tolerance;
    end
  end

  qau_front #(.WORD_BITS(WORD_BITS)) u_front (
    .cmd   (cmd),
    .a_real(a_real),
    .a_i   (a_i),
    .a_j   (a_j),
    .a_k   (a_k),
    .b_real(b_real),
    .b_i   (b_i),
    .b_j   (b_j),
    .b_k   (b_k),
    .scalar(scalar),
    .item  (item_in)
  );

  // command queue between decode and execute
  qau_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(item_in),
    .full (full),
    .pop  (cq_pop),
    .rdata(item_q),
    .empty(cq_empty)
  );

  qau_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .tol     (tol),
    .in_empty(cq_empty),
    .in_item (item_q),
    .in_pop  (cq_pop),
    .out_full(rq_full),
    .out_push(rq_push),
    .out_item(res_d)
  );

  // result queue facing the consumer
  qau_fifo #(.WIDTH(OUT_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (rq_push),
    .wdata(res_d),
    .full (rq_full),
    .pop  (pop),
    .rdata(res_q),
    .empty(empty)
  );

  assign res_real   = res_q[OUT_W-1 -: W];
  assign res_i      = res_q[OUT_W-1-W -: W];
  assign res_j      = res_q[OUT_W-1-2*W -: W];
  assign res_k      = res_q[OUT_W-1-3*W -: W];
  assign res_scalar = res_q[OUT_W-1-4*W -: W];
  assign is_unit    = res_q[2];
  assign status     = res_q[1:0];

endmodule
`default_nettype wire

### rtl/qau_fifo.sv
`default_nettype none
module qau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        mem[wptr] <= wdata;
        wptr      <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/qau_front.sv
`default_nettype none
module qau_front #(
  parameter int WORD_BITS = qau_pkg::WORD_BITS_DEF
) (
  input  wire logic [3:0]           cmd,
  input  wire logic [WORD_BITS-1:0] a_real,
  input  wire logic [WORD_BITS-1:0] a_i,
  input  wire logic [WORD_BITS-1:0] a_j,
  input  wire logic [WORD_BITS-1:0] a_k,
  input  wire logic [WORD_BITS-1:0] b_real,
  input  wire logic [WORD_BITS-1:0] b_i,
  input  wire logic [WORD_BITS-1:0] b_j,
  input  wire logic [WORD_BITS-1:0] b_k,
  input  wire logic [WORD_BITS-1:0] scalar,
  output logic [qau_pkg::CTL_W+9*WORD_BITS-1:0] item
);

  qau_pkg::qau_ctl_t ctl;

  always_comb begin
    ctl.op       = cmd;
    ctl.valid_op = cmd inside {[qau_pkg::OP_ADD:qau_pkg::OP_ROT]};
    ctl.zero_div = (scalar == '0);
  end

  assign item = {ctl, a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k, scalar};

endmodule
`default_nettype wire

### rtl/qau_divsqrt.sv
`default_nettype none
module qau_divsqrt #(
  parameter int WORD_BITS = qau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           sqrt_mode,
  input  wire logic [WORD_BITS+FRAC_BITS-1:0] num,
  input  wire logic [WORD_BITS:0]             den,
  input  wire logic [2*WORD_BITS+1:0]         rad,
  output logic                                done,
  output logic [WORD_BITS+FRAC_BITS-1:0]      q
);

  localparam int W  = WORD_BITS;
  localparam int DN = WORD_BITS + FRAC_BITS;
  localparam int NS = W + 1;
  localparam int CW = $clog2(DN + 1);

  logic            running;
  logic            fin;
  logic            mode;
  logic [CW-1:0]   cnt;
  logic [DN-1:0]   dnum;
  logic [W:0]      drem;
  logic [DN-1:0]   dquo;
  logic [W:0]      dden;
  logic [2*W+1:0]  srad;
  logic [W+1:0]    srem;
  logic [W:0]      sroot;

  logic [W+1:0]    drem_sh;
  logic            dge;
  logic [W+1:0]    drem_diff;
  logic [W+3:0]    srem_sh;
  logic [W+3:0]    trial;
  logic            sge;
  logic [W+3:0]    srem_diff;

  always_comb begin
    drem_sh   = {drem, dnum[DN-1]};
    dge       = (drem_sh >= {1'b0, dden});
    drem_diff = drem_sh - {1'b0, dden};
    srem_sh   = {srem, srad[2*W+1 -: 2]};
    trial     = {1'b0, sroot, 2'b01};
    sge       = (srem_sh >= trial);
    srem_diff = srem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        fin     <= 1'b0;
        mode    <= sqrt_mode;
        cnt     <= sqrt_mode ? CW'(NS) : CW'(DN);
        dnum    <= num;
        dden    <= den;
        drem    <= '0;
        dquo    <= '0;
        srad    <= rad;
        srem    <= '0;
        sroot   <= '0;
      end else if (running) begin
        if (mode) begin
          srem  <= sge ? srem_diff[W+1:0] : srem_sh[W+1:0];
          sroot <= {sroot[W-1:0], sge};
          srad  <= {srad[2*W-1:0], 2'b00};
        end else begin
          drem <= dge ? drem_diff[W:0] : drem_sh[W:0];
          dquo <= {dquo[DN-2:0], dge};
          dnum <= {dnum[DN-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        // round the root up when the remainder exceeds it
        q    <= mode ? DN'(sroot) + DN'(srem > {1'b0, sroot}) : dquo;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/qau_back.sv
`default_nettype none
module qau_back #(
  parameter int WORD_BITS = qau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [qau_pkg::TOL_W-1:0]             tol,
  input  wire logic                                  in_empty,
  input  wire logic [qau_pkg::CTL_W+9*WORD_BITS-1:0] in_item,
  output logic                                       in_pop,
  input  wire logic                                  out_full,
  output logic                                       out_push,
  output logic [5*WORD_BITS+2:0]                     out_item
);

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int ACC_W  = 2 * W + 3;
  localparam int PW     = 2 * W + 2;
  localparam int DN     = W + F;
  localparam int ITEM_W = qau_pkg::CTL_W + 9 * W;

  localparam logic signed [ACC_W-1:0] I64MAX =
    ACC_W'((ACC_W'(1) << 63) - ACC_W'(1));
  localparam logic signed [ACC_W-1:0] I64MIN = ~I64MAX;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (F - 1);
  localparam logic signed [ACC_W-1:0] ONE_A  = ACC_W'(1) << F;
  localparam logic signed [W-1:0]     WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]     WMIN   = {1'b1, {(W-1){1'b0}}};

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SIMPLE = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_RND    = 4'd4;
  localparam logic [3:0] S_FIN    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic [2:0] P_SQA   = 3'd0;
  localparam logic [2:0] P_SQB   = 3'd1;
  localparam logic [2:0] P_SCALE = 3'd2;
  localparam logic [2:0] P_DOT   = 3'd3;
  localparam logic [2:0] P_HAM   = 3'd4;
  localparam logic [2:0] P_ROT1  = 3'd5;
  localparam logic [2:0] P_ROT2  = 3'd6;

  // clamp to the 64-bit range, only reachable at the widest word size
  function automatic logic signed [ACC_W-1:0] clamp64(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (ACC_W > 64) begin
      if (v > I64MAX) c = I64MAX;
      else if (v < I64MIN) c = I64MIN;
    end
    return c;
  endfunction

  qau_pkg::qau_ctl_t ctl_in;
  logic signed [W-1:0] in_a [4];
  logic signed [W-1:0] in_b [4];
  logic signed [W-1:0] in_sc;

  logic [3:0]  state;
  logic [3:0]  op;
  logic [2:0]  pass;
  logic [1:0]  oi;
  logic [1:0]  ti;
  logic signed [W-1:0] a [4];
  logic signed [W-1:0] b [4];
  logic signed [W-1:0] t [4];
  logic signed [W-1:0] r [4];
  logic signed [W-1:0] rs;
  logic        unit;
  logic        ovf;
  logic        dz;
  logic        sq_mode;
  logic [W:0]  den;
  logic        dneg;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] racc;
  logic signed [PW-1:0]    prod;
  logic        pneg;

  logic [1:0]  qi;
  logic signed [W:0] mx;
  logic signed [W:0] my;
  logic        mneg;
  logic [1:0]  ti_last;
  logic        one_out;
  logic signed [ACC_W-1:0] addend;
  logic signed [W-1:0] w_val;
  logic        w_ovf;
  logic signed [ACC_W-1:0] tolx;
  logic        unit_ok;
  logic signed [W-1:0] s_val [4];
  logic        s_ovf;
  logic signed [W:0] aabs;
  logic [DN-1:0] num;
  logic        ds_start;
  logic        ds_done;
  logic [DN-1:0] ds_q;
  logic        q_neg;
  logic signed [W-1:0] q_val;
  logic        q_ovf;
  logic [1:0]  st;

  always_comb begin
    ctl_in = in_item[ITEM_W-1 -: qau_pkg::CTL_W];
    for (int i = 0; i < 4; i++) begin
      in_a[i] = in_item[(8-i)*W +: W];
      in_b[i] = in_item[(4-i)*W +: W];
    end
    in_sc = in_item[W-1:0];
  end

  // multiplier operand select
  assign qi = oi ^ ti;

  always_comb begin
    mx   = '0;
    my   = '0;
    mneg = 1'b0;
    case (pass)
      P_SQA: begin
        mx = {a[ti][W-1], a[ti]};
        my = {a[ti][W-1], a[ti]};
      end
      P_SQB: begin
        mx = {b[ti][W-1], b[ti]};
        my = {b[ti][W-1], b[ti]};
      end
      P_SCALE: begin
        mx = {a[oi][W-1], a[oi]};
        my = {in_sc_r[W-1], in_sc_r};
      end
      P_DOT: begin
        mx = {a[ti][W-1], a[ti]};
        my = {b[ti][W-1], b[ti]};
      end
      P_HAM: begin
        mx   = {a[ti][W-1], a[ti]};
        my   = {b[qi][W-1], b[qi]};
        mneg = qau_pkg::ham_neg(oi, ti);
      end
      P_ROT1: begin
        mx   = {b[ti][W-1], b[ti]};
        my   = (qi == 2'd0) ? '0 : {a[qi][W-1], a[qi]};
        mneg = qau_pkg::ham_neg(oi, ti);
      end
      P_ROT2: begin
        mx   = {t[ti][W-1], t[ti]};
        my   = (qi == 2'd0) ? {b[0][W-1], b[0]} : -{b[qi][W-1], b[qi]};
        mneg = qau_pkg::ham_neg(oi, ti);
      end
      default: begin
        mx = '0;
      end
    endcase
  end

  logic signed [W-1:0] in_sc_r;

  assign ti_last = (pass == P_SCALE) ? 2'd0 : 2'd3;
  assign one_out = (pass == P_SQA) || (pass == P_SQB) || (pass == P_DOT);
  assign addend  = {{(ACC_W-PW){prod[PW-1]}}, prod};

  // word saturation of the rounded sum, and its unit check against tol
  always_comb begin
    w_ovf = !((&racc[ACC_W-1:W-1]) || !(|racc[ACC_W-1:W-1]));
    w_val = w_ovf ? (racc[ACC_W-1] ? WMIN : WMAX) : racc[W-1:0];
    tolx  = ACC_W'(tol);
    unit_ok = (racc > ONE_A - tolx) && (racc < ONE_A + tolx);
  end

  // add, sub, negate, conjugate
  always_comb begin
    logic signed [W:0] sx;
    s_ovf = 1'b0;
    for (int i = 0; i < 4; i++) begin
      case (op)
        qau_pkg::OP_ADD: sx = {a[i][W-1], a[i]} + {b[i][W-1], b[i]};
        qau_pkg::OP_SUB: sx = {a[i][W-1], a[i]} - {b[i][W-1], b[i]};
        qau_pkg::OP_NEG: sx = -{a[i][W-1], a[i]};
        default:         sx = (i == 0) ? {a[i][W-1], a[i]} : -{a[i][W-1], a[i]};
      endcase
      if (sx[W] != sx[W-1]) begin
        s_ovf    = 1'b1;
        s_val[i] = sx[W] ? WMIN : WMAX;
      end else begin
        s_val[i] = sx[W-1:0];
      end
    end
  end

  // divider operands: (|n| << F) + d/2 over d
  always_comb begin
    aabs = a[oi][W-1] ? -{a[oi][W-1], a[oi]} : {a[oi][W-1], a[oi]};
    num  = DN'({aabs, {F{1'b0}}}) + DN'(den >> 1);
  end

  assign ds_start = (state == S_DSTART);

  qau_divsqrt #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (ds_start),
    .sqrt_mode(sq_mode),
    .num      (num),
    .den      (den),
    .rad      (acc[ACC_W-2:0]),
    .done     (ds_done),
    .q        (ds_q)
  );

  // quotient or root to a signed word
  always_comb begin
    q_neg = !sq_mode && (a[oi][W-1] ^ dneg);
    if (q_neg) begin
      q_ovf = (|ds_q[DN-1:W]) || (ds_q[W-1] && (|ds_q[W-2:0]));
      q_val = q_ovf ? WMIN : W'(-ds_q);
    end else begin
      q_ovf = |ds_q[DN-1:W-1];
      q_val = q_ovf ? WMAX : ds_q[W-1:0];
    end
  end

  always_comb begin
    if (dz)                                   st = qau_pkg::ST_DZ;
    else if (op == qau_pkg::OP_ROT && !unit)  st = qau_pkg::ST_NOTUNIT;
    else if (ovf)                             st = qau_pkg::ST_SAT;
    else                                      st = qau_pkg::ST_OK;
  end

  assign in_pop   = (state == S_IDLE) && !in_empty;
  assign out_push = (state == S_OUT) && !out_full;
  assign out_item = {r[0], r[1], r[2], r[3], rs, unit, st};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!in_empty) begin
            op      <= ctl_in.op;
            a       <= in_a;
            b       <= in_b;
            in_sc_r <= in_sc;
            for (int i = 0; i < 4; i++) r[i] <= '0;
            rs      <= '0;
            unit    <= 1'b0;
            ovf     <= 1'b0;
            dz      <= 1'b0;
            oi      <= '0;
            ti      <= '0;
            acc     <= '0;
            sq_mode <= 1'b0;
            den     <= in_sc[W-1] ? -{in_sc[W-1], in_sc} : {in_sc[W-1], in_sc};
            dneg    <= in_sc[W-1];
            pass    <= P_SQA;
            if (!ctl_in.valid_op) begin
              state <= S_OUT;
            end else begin
              case (ctl_in.op)
                qau_pkg::OP_ADD, qau_pkg::OP_SUB,
                qau_pkg::OP_NEG, qau_pkg::OP_CONJ: state <= S_SIMPLE;
                qau_pkg::OP_SCALE: begin
                  pass  <= P_SCALE;
                  state <= S_MUL;
                end
                qau_pkg::OP_DIV: begin
                  dz    <= ctl_in.zero_div;
                  state <= ctl_in.zero_div ? S_OUT : S_DSTART;
                end
                qau_pkg::OP_MUL: begin
                  pass  <= P_HAM;
                  state <= S_MUL;
                end
                qau_pkg::OP_DOT: begin
                  pass  <= P_DOT;
                  state <= S_MUL;
                end
                qau_pkg::OP_ROT: begin
                  pass  <= P_SQB;
                  state <= S_MUL;
                end
                default: state <= S_MUL;
              endcase
            end
          end
        end
        S_SIMPLE: begin
          r     <= s_val;
          ovf   <= s_ovf;
          state <= S_OUT;
        end
        S_MUL: begin
          prod  <= PW'(mx * my);
          pneg  <= mneg;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= clamp64(pneg ? acc - addend : acc + addend);
          if (ti == ti_last) begin
            state <= S_RND;
          end else begin
            ti    <= ti + 2'd1;
            state <= S_MUL;
          end
        end
        S_RND: begin
          racc  <= clamp64(acc + HALF) >>> F;
          state <= S_FIN;
        end
        S_FIN: begin
          ti <= '0;
          case (pass)
            P_SQA, P_SQB: begin
              if (op == qau_pkg::OP_LEN || op == qau_pkg::OP_NORM) begin
                sq_mode <= 1'b1;
                state   <= S_DSTART;
              end else begin
                unit <= unit_ok;
                rs   <= w_val;
                ovf  <= ovf | w_ovf;
                if (op == qau_pkg::OP_ROT) begin
                  pass  <= P_ROT1;
                  oi    <= '0;
                  acc   <= '0;
                  state <= S_MUL;
                end else begin
                  state <= S_OUT;
                end
              end
            end
            P_DOT: begin
              rs    <= w_val;
              ovf   <= ovf | w_ovf;
              state <= S_OUT;
            end
            P_ROT1: begin
              t[oi] <= w_val;
              ovf   <= ovf | w_ovf;
              acc   <= '0;
              oi    <= oi + 2'd1;
              if (oi == 2'd3) pass <= P_ROT2;
              state <= S_MUL;
            end
            default: begin
              // rotation drops the real part but still flags its overflow
              r[oi] <= (pass == P_ROT2 && oi == 2'd0) ? '0 : w_val;
              ovf   <= ovf | w_ovf;
              acc   <= '0;
              oi    <= oi + 2'd1;
              state <= (oi == 2'd3 || one_out) ? S_OUT : S_MUL;
            end
          endcase
        end
        S_DSTART: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (ds_done) begin
            if (sq_mode) begin
              if (op == qau_pkg::OP_LEN) begin
                rs    <= q_val;
                ovf   <= ovf | q_ovf;
                state <= S_OUT;
              end else if (ds_q == '0) begin
                dz    <= 1'b1;
                state <= S_OUT;
              end else begin
                den     <= ds_q[W:0];
                dneg    <= 1'b0;
                sq_mode <= 1'b0;
                oi      <= '0;
                state   <= S_DSTART;
              end
            end else begin
              r[oi] <= q_val;
              ovf   <= ovf | q_ovf;
              oi    <= oi + 2'd1;
              state <= (oi == 2'd3) ? S_OUT : S_DSTART;
            end
          end
        end
        S_OUT: begin
          if (!out_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### tb/tb.sv
module tb;
  import qau_pkg::*;

  localparam int W = 16;
  localparam int F = 12;
  localparam longint WMAX = 32767;
  localparam longint WMIN = -32768;
  localparam longint ONE = 4096;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [3:0] op;
    longint a[4];
    longint b[4];
    longint sc;
  } quat_cmd_t;

  // One result beat: res_real, res_i, res_j, res_k, res_scalar, is_unit, status.
  typedef struct {
    longint f[7];
  } quat_res_t;

  logic clk = 0;
  logic rst = 1;
  logic unit_tolerance_we = 0;
  logic [TOL_W-1:0] unit_tolerance = '0;
  logic push = 0;
  logic full;
  logic [3:0] cmd = '0;
  logic signed [W-1:0] a_real = '0, a_i = '0, a_j = '0, a_k = '0;
  logic signed [W-1:0] b_real = '0, b_i = '0, b_j = '0, b_k = '0;
  logic signed [W-1:0] scalar = '0;
  logic empty;
  logic pop = 0;
  logic signed [W-1:0] res_real, res_i, res_j, res_k, res_scalar;
  logic is_unit;
  logic [1:0] status;

  quaternion_arithmetic_unit_top uut (
    .clk(clk), .rst(rst),
    .unit_tolerance_we(unit_tolerance_we), .unit_tolerance(unit_tolerance),
    .push(push), .full(full), .cmd(cmd),
    .a_real(a_real), .a_i(a_i), .a_j(a_j), .a_k(a_k),
    .b_real(b_real), .b_i(b_i), .b_j(b_j), .b_k(b_k),
    .scalar(scalar), .empty(empty), .pop(pop),
    .res_real(res_real), .res_i(res_i), .res_j(res_j), .res_k(res_k),
    .res_scalar(res_scalar), .is_unit(is_unit), .status(status)
  );

  // Predictor copy of the tolerance register, and the results still owed.
  longint tol_now = TOL_RESET;
  quat_res_t owed_results[$];
  int fail_count = 0;
  int send_gap_pct = 0;
  int pop_stall_pct = 0;
  int pop_hold_cycles = 0;
  longint cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------
  // round half up at F fraction bits (>>> on signed longint floors)
  function automatic longint round_q(longint x);
    return (x + (longint'(1) << (F - 1))) >>> F;
  endfunction

  function automatic longint clamp_word(longint v, inout bit ovf);
    if (v > WMAX) begin
      ovf = 1;
      return WMAX;
    end
    if (v < WMIN) begin
      ovf = 1;
      return WMIN;
    end
    return v;
  endfunction

  // quotient in Q format, rounded to nearest with ties away from zero
  function automatic longint quot_q(longint n, longint d, inout bit ovf);
    longint unsigned un, ud, q;
    longint r;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = ((un << F) + ud / 2) / ud;
    r = q;
    if ((n < 0) != (d < 0)) r = -r;
    return clamp_word(r, ovf);
  endfunction

  function automatic longint sqrt_round(longint unsigned s);
    longint unsigned res, bitv, x;
    res = 0;
    bitv = longint'(1) << 62;
    x = s;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (s - res * res > res) res++;
    return res;
  endfunction

  function automatic longint len_sq(longint q[4]);
    return q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3];
  endfunction

  function automatic bit near_unit(longint l2);
    longint d;
    d = l2 - ONE;
    if (d < 0) d = -d;
    return d < tol_now;
  endfunction

  function automatic void ham_product(input longint p[4], input longint q[4],
                                      output longint r[4], inout bit ovf);
    r[0] = clamp_word(round_q(p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3]), ovf);
    r[1] = clamp_word(round_q(p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2]), ovf);
    r[2] = clamp_word(round_q(p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1]), ovf);
    r[3] = clamp_word(round_q(p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0]), ovf);
  endfunction

  function automatic quat_res_t quat_alu(quat_cmd_t c);
    quat_res_t o;
    longint r[4], v[4], t[4], cb[4];
    longint rs, acc, lv, l2;
    bit ovf, unit, dz, notunit;
    r = '{0, 0, 0, 0};
    rs = 0;
    ovf = 0;
    unit = 0;
    dz = 0;
    notunit = 0;
    case (c.op)
      OP_ADD: for (int i = 0; i < 4; i++) r[i] = clamp_word(c.a[i] + c.b[i], ovf);
      OP_SUB: for (int i = 0; i < 4; i++) r[i] = clamp_word(c.a[i] - c.b[i], ovf);
      OP_NEG: for (int i = 0; i < 4; i++) r[i] = clamp_word(-c.a[i], ovf);
      OP_CONJ: begin
        r[0] = c.a[0];
        for (int i = 1; i < 4; i++) r[i] = clamp_word(-c.a[i], ovf);
      end
      OP_SCALE: for (int i = 0; i < 4; i++) r[i] = clamp_word(round_q(c.a[i] * c.sc), ovf);
      OP_DIV: begin
        if (c.sc == 0) dz = 1;
        else for (int i = 0; i < 4; i++) r[i] = quot_q(c.a[i], c.sc, ovf);
      end
      OP_MUL: ham_product(c.a, c.b, r, ovf);
      OP_DOT: begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += c.a[i] * c.b[i];
        rs = clamp_word(round_q(acc), ovf);
      end
      OP_LEN, OP_NORM: begin
        lv = sqrt_round(len_sq(c.a));
        if (c.op == OP_LEN) rs = clamp_word(lv, ovf);
        else if (lv == 0) dz = 1;
        else for (int i = 0; i < 4; i++) r[i] = quot_q(c.a[i], lv, ovf);
      end
      OP_UNIT: begin
        l2 = round_q(len_sq(c.a));
        unit = near_unit(l2);
        rs = clamp_word(l2, ovf);
      end
      OP_ROT: begin
        l2 = round_q(len_sq(c.b));
        unit = near_unit(l2);
        notunit = !unit;
        rs = clamp_word(l2, ovf);
        v = '{0, c.a[1], c.a[2], c.a[3]};
        cb = '{c.b[0], -c.b[1], -c.b[2], -c.b[3]};
        ham_product(c.b, v, t, ovf);
        ham_product(t, cb, r, ovf);
        r[0] = 0;
      end
      default: ;
    endcase
    if (dz) begin
      r = '{0, 0, 0, 0};
      rs = 0;
    end
    for (int i = 0; i < 4; i++) o.f[i] = r[i];
    o.f[4] = rs;
    o.f[5] = unit;
    o.f[6] = dz ? ST_DZ : (notunit ? ST_NOTUNIT : (ovf ? ST_SAT : ST_OK));
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stalls, long hold-off on request, field checks
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    quat_res_t want;
    longint got[7];
    string names[7];
    names = '{"res_real", "res_i", "res_j", "res_k", "res_scalar", "is_unit", "status"};
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          $error("result beat with nothing outstanding");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          got = '{res_real, res_i, res_j, res_k, res_scalar, is_unit, status};
          for (int i = 0; i < 7; i++) begin
            if (got[i] != want.f[i]) begin
              $error("%s: expected %0d, got %0d", names[i], want.f[i], got[i]);
              fail_count++;
            end
          end
        end
      end
      if (pop_hold_cycles > 0) begin
        pop_hold_cycles--;
        pop <= 0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------
  // Drives one command beat, waits for it to be taken, then logs the prediction.
  task automatic send_cmd(quat_cmd_t c);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    cmd <= c.op;
    a_real <= c.a[0]; a_i <= c.a[1]; a_j <= c.a[2]; a_k <= c.a[3];
    b_real <= c.b[0]; b_i <= c.b[1]; b_j <= c.b[2]; b_k <= c.b[3];
    scalar <= c.sc;
    @(posedge clk);
    while (full) @(posedge clk);
    owed_results.push_back(quat_alu(c));
  endtask

  task automatic wait_drained();
    push <= 0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Tolerance writes only happen with the pipe fully idle.
  task automatic set_tolerance(int v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    unit_tolerance_we <= 1;
    unit_tolerance <= v;
    @(posedge clk);
    unit_tolerance_we <= 0;
    tol_now = v;
  endtask

  function automatic quat_cmd_t mk(logic [3:0] op, longint a0, longint a1, longint a2,
                                   longint a3, longint b0, longint b1, longint b2,
                                   longint b3, longint sc);
    quat_cmd_t c;
    c.op = op;
    c.a = '{a0, a1, a2, a3};
    c.b = '{b0, b1, b2, b3};
    c.sc = sc;
    return c;
  endfunction

  function automatic longint rand_word();
    longint pick[7];
    pick = '{WMIN, WMAX, 0, ONE, -ONE, 1, -1};
    case ($urandom_range(3))
      0: return longint'($urandom_range(65535)) - 32768;
      1: return pick[$urandom_range(6)];
      2: return longint'($urandom_range(8192)) - 4096;
      default: return longint'($urandom_range(256)) - 128;
    endcase
  endfunction

  // Roughly unit quaternion: random direction scaled to 1.0, a few LSB off.
  function automatic void rand_unit(output longint q[4]);
    real v[4];
    real nrm;
    nrm = 0;
    for (int i = 0; i < 4; i++) begin
      v[i] = real'($urandom_range(2000)) - 1000.0;
      nrm += v[i] * v[i];
    end
    if (nrm == 0) begin
      v[0] = 1.0;
      nrm = 1.0;
    end
    nrm = $sqrt(nrm);
    for (int i = 0; i < 4; i++) q[i] = $rtoi(v[i] * 4096.0 / nrm);
  endfunction

  function automatic quat_cmd_t rand_cmd();
    quat_cmd_t c;
    c.op = ($urandom_range(9) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(11));
    for (int i = 0; i < 4; i++) begin
      c.a[i] = rand_word();
      c.b[i] = rand_word();
    end
    c.sc = rand_word();
    if (c.op == OP_ROT && $urandom_range(9) < 7) rand_unit(c.b);
    if (c.op == OP_UNIT && $urandom_range(1) == 0) rand_unit(c.a);
    if (c.op == OP_DIV && $urandom_range(19) == 0) c.sc = 0;
    if (c.op == OP_NORM && $urandom_range(19) == 0) c.a = '{0, 0, 0, 0};
    return c;
  endfunction

  // Extremes, every opcode, divide by zero, saturation, non-unit rotation.
  task automatic test_directed();
    send_cmd(mk(OP_ADD, WMAX, WMIN, 1, -1, 1, -1, WMAX, WMIN, 0));
    send_cmd(mk(OP_SUB, WMIN, WMAX, 0, 5, 1, -1, 0, -5, 0));
    send_cmd(mk(OP_NEG, WMIN, WMAX, 0, -ONE, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_CONJ, WMIN, WMIN, 7, WMAX, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_SCALE, ONE, -ONE, WMAX, WMIN, 0, 0, 0, 0, WMIN));
    send_cmd(mk(OP_SCALE, 3, -3, 2048, -2048, 0, 0, 0, 0, 2048));
    send_cmd(mk(OP_DIV, ONE, -ONE, WMAX, WMIN, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_DIV, ONE, -ONE, WMAX, WMIN, 0, 0, 0, 0, 3 * ONE));
    send_cmd(mk(OP_DIV, 1, -1, 3, -3, 0, 0, 0, 0, -2 * ONE));
    send_cmd(mk(OP_DIV, WMAX, WMIN, 1, 0, 0, 0, 0, 0, 1));
    send_cmd(mk(OP_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0, 0));
    send_cmd(mk(OP_MUL, 0, ONE, 0, 0, 0, 0, ONE, 0, 0));
    send_cmd(mk(OP_MUL, WMIN, WMIN, WMIN, WMIN, WMIN, WMAX, WMIN, WMAX, 0));
    send_cmd(mk(OP_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0));
    send_cmd(mk(OP_DOT, ONE, 2 * ONE, 0, 0, -ONE, ONE, 0, 0, 0));
    send_cmd(mk(OP_LEN, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_LEN, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_NORM, WMIN, WMAX, -7, 9, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_UNIT, ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_UNIT, 2896, 2896, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_ROT, 0, ONE, 0, 0, 2896, 0, 0, 2896, 0));
    send_cmd(mk(OP_ROT, 0, WMAX, WMIN, WMAX, 2 * ONE, 0, ONE, 0, 0));
    send_cmd(mk(4'd12, 1, 2, 3, 4, 5, 6, 7, 8, 9));
    send_cmd(mk(4'd15, WMIN, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Receiver holds off while commands keep coming, so full must assert;
  // then the sender waits until everything has come back.
  task automatic test_backpressure();
    send_gap_pct = 0;
    pop_stall_pct = 0;
    pop_hold_cycles = 600;
    repeat (20) send_cmd(rand_cmd());
    wait_drained();
  endtask

  task automatic test_random_phase(int gap, int stall, int n);
    send_gap_pct = gap;
    pop_stall_pct = stall;
    repeat (n) send_cmd(rand_cmd());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 330);
    set_tolerance(0);
    test_random_phase(48, 0, 330);
    set_tolerance(4095);
    test_random_phase(0, 48, 330);
    set_tolerance($urandom_range(1, 64));
    test_random_phase(22, 22, 330);
    set_tolerance(4);
    test_random_phase(0, 0, 40);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
